FILE: hdl/rws_pkg.sv
`timescale 1ns / 1ps

package rws_pkg;

	localparam int COORD_W = 32;
	localparam int LEN_W   = 24;
	localparam int MUL_W   = 34;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int SQ_W    = 64;
	localparam int ROOT_W  = 32;
	localparam int REM_W   = 34;
	localparam int SQRT_CW = 5;
	localparam int ATAN_N  = 32;
	localparam int IDX_W   = 5;

	localparam logic [LEN_W-1:0] STEP_LEN_RESET = 24'd65536;

	// 3*ra < 65536 and 3*ra < 131072, expressed on ra itself
	localparam logic [15:0] AXIS_Y_START = 16'd21846;
	localparam logic [15:0] AXIS_Z_START = 16'd43691;

	localparam logic signed [MUL_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [60:0] Q60_ONE = 61'h1000_0000_0000_0000;

	localparam logic [31:0] ATAN_TURN [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef enum logic [1:0] {
		REQ_LATTICE = 2'd0,
		REQ_ISO     = 2'd1,
		REQ_ORIGIN  = 2'd2
	} req_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_ACCEPT, OP_LAT, OP_CLR, OP_MUL_CC, OP_ISO_LOAD,
		OP_MUL_TX, OP_MUL_TY, OP_MUL_DX, OP_MUL_DY, OP_MUL_DZ, OP_WB_DZ,
		OP_SQ_X, OP_SQ_Y, OP_SQ_Z, OP_SQ_ACC, OP_DIST_LOAD, OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LAT, ST_CLR, ST_CC, ST_ISO_LOAD, ST_ISO_RUN,
		ST_TX, ST_TY, ST_DX, ST_DY, ST_DZ, ST_WDZ,
		ST_SQX, ST_SQY, ST_SQZ, ST_ACC, ST_DLOAD, ST_DRUN, ST_OUT
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic sqrt_busy;
		logic out_valid;
	} stat_t;

	function automatic logic signed [COORD_W-1:0] sat_add(
		input logic signed [COORD_W-1:0] a,
		input logic signed [MUL_W-1:0] d
	);
		logic signed [MUL_W:0] s;
		s = MUL_W'(0) + {{(MUL_W-COORD_W+1){a[COORD_W-1]}}, a} + {d[MUL_W-1], d};
		if (s > $signed({{(MUL_W-COORD_W+2){1'b0}}, {(COORD_W-1){1'b1}}}))
			return {1'b0, {(COORD_W-1){1'b1}}};
		else if (s < $signed({{(MUL_W-COORD_W+2){1'b1}}, {(COORD_W-1){1'b0}}}))
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return s[COORD_W-1:0];
	endfunction

	// round half up at bit 30
	function automatic logic signed [MUL_W-1:0] rnd30(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + $signed({{(PROD_W-30){1'b0}}, 1'b1, 29'd0});
		return t[MUL_W+29:30];
	endfunction

endpackage

FILE: hdl/rws_sqrt.sv
`timescale 1ns / 1ps

module rws_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [rws_pkg::SQ_W-1:0]    value,
	output logic [rws_pkg::ROOT_W-1:0]  root,
	output logic                        busy
);
	import rws_pkg::*;

	logic [SQ_W-1:0]    v_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [SQRT_CW-1:0] cnt_q;
	logic               busy_q;
	logic [REM_W+1:0]   rem_sh, trial, rem_sub;
	logic               ge;

	// one result bit per cycle: two radicand bits shift into the remainder
	always_comb begin
		rem_sh  = {rem_q, v_q[SQ_W-1:SQ_W-2]};
		trial   = {2'b00, root_q, 2'b01};
		ge      = rem_sh >= trial;
		rem_sub = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == {SQRT_CW{1'b1}})
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			v_q    <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[SQ_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign busy = busy_q;

endmodule

FILE: hdl/rws_cordic.sv
`timescale 1ns / 1ps

module rws_cordic #(
	parameter int CORDIC_STEPS = 18
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic [15:0]                       phase_in,
	output logic signed [rws_pkg::MUL_W-1:0]  cos_out,
	output logic signed [rws_pkg::MUL_W-1:0]  sin_out
);
	import rws_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CORDIC_STEPS - 1);

	logic signed [MUL_W-1:0] x_q, y_q, z_q;
	logic signed [MUL_W-1:0] x_sh, y_sh, atan;
	logic [IDX_W-1:0]        idx_q;
	logic                    busy_q, flip_q, flip;

	// fold the turn into [-90, 90) degrees; the fold negates the result
	assign flip = (phase_in[15:14] == 2'b01) || (phase_in[15:14] == 2'b10);

	always_comb begin
		x_sh = x_q >>> idx_q;
		y_sh = y_q >>> idx_q;
		atan = $signed({2'b00, ATAN_TURN[idx_q]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == LAST_IDX)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= $signed({{(MUL_W-32){phase_in[15] ^ flip}},
				phase_in[15] ^ flip, phase_in[14:0], 16'd0});
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[MUL_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan;
			end
		end
	end

	assign cos_out = flip_q ? -x_q : x_q;
	assign sin_out = flip_q ? -y_q : y_q;

endmodule

FILE: hdl/rws_datapath.sv
`timescale 1ns / 1ps

module rws_datapath #(
	parameter int CORDIC_STEPS = 18
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rws_pkg::cmd_t                       cmd,
	output rws_pkg::stat_t                      stat,
	input  logic [15:0]                         rand_a,
	input  logic [15:0]                         rand_b,
	input  logic                                cfg_valid,
	input  logic [rws_pkg::LEN_W-1:0]           cfg_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [rws_pkg::COORD_W-1:0]  pos_x,
	output logic signed [rws_pkg::COORD_W-1:0]  pos_y,
	output logic signed [rws_pkg::COORD_W-1:0]  pos_z,
	output logic [rws_pkg::SQ_W-1:0]            square_distance,
	output logic [rws_pkg::ROOT_W-1:0]          distance
);
	import rws_pkg::*;

	logic [LEN_W-1:0]          step_len_q;
	logic signed [COORD_W-1:0] x_q, y_q, z_q;
	logic [15:0]               ra_q, rb_q;
	logic signed [COORD_W-1:0] c_q;
	logic signed [MUL_W-1:0]   tx_q, ty_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [SQ_W-1:0]           acc_q;
	logic                      out_valid_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b, len, cos_v, sin_v, s_v, lat_d;
	logic signed [MUL_W-1:0]   prod_rnd;
	logic                      sqrt_load, sqrt_busy;
	logic [SQ_W-1:0]           sqrt_val;
	logic [ROOT_W-1:0]         root;

	assign len      = $signed({{(MUL_W-LEN_W){1'b0}}, step_len_q});
	assign s_v      = $signed({{(MUL_W-ROOT_W){1'b0}}, root});
	assign prod_rnd = rnd30(prod_q);
	assign lat_d    = rb_q[15] ? len : -len;

	always_comb begin
		case (cmd.op)
			OP_MUL_CC: begin mul_a = MUL_W'(c_q);  mul_b = MUL_W'(c_q); end
			OP_MUL_TX: begin mul_a = s_v;          mul_b = cos_v;       end
			OP_MUL_TY: begin mul_a = s_v;          mul_b = sin_v;       end
			OP_MUL_DX: begin mul_a = tx_q;         mul_b = len;         end
			OP_MUL_DY: begin mul_a = ty_q;         mul_b = len;         end
			OP_MUL_DZ: begin mul_a = MUL_W'(c_q);  mul_b = len;         end
			OP_SQ_X:   begin mul_a = MUL_W'(x_q);  mul_b = MUL_W'(x_q); end
			OP_SQ_Y:   begin mul_a = MUL_W'(y_q);  mul_b = MUL_W'(y_q); end
			OP_SQ_Z:   begin mul_a = MUL_W'(z_q);  mul_b = MUL_W'(z_q); end
			default:   begin mul_a = '0;           mul_b = '0;          end
		endcase
	end

	always_comb begin
		sqrt_load = 1'b0;
		sqrt_val  = acc_q;
		case (cmd.op)
			OP_ISO_LOAD: begin
				sqrt_load = 1'b1;
				sqrt_val  = {3'b000, Q60_ONE - prod_q[60:0]};
			end
			OP_DIST_LOAD: sqrt_load = 1'b1;
			default:      sqrt_load = 1'b0;
		endcase
	end

	rws_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (sqrt_load),
		.value  (sqrt_val),
		.root   (root),
		.busy   (sqrt_busy)
	);

	rws_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.op == OP_ISO_LOAD),
		.phase_in (ra_q),
		.cos_out  (cos_v),
		.sin_out  (sin_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_len_q  <= STEP_LEN_RESET;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				step_len_q <= cfg_data;
			if (cmd.op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (cmd.op)
				OP_LAT: begin
					if (ra_q < AXIS_Y_START)
						x_q <= sat_add(x_q, lat_d);
					else if (ra_q < AXIS_Z_START)
						y_q <= sat_add(y_q, lat_d);
					else
						z_q <= sat_add(z_q, lat_d);
				end
				OP_CLR: begin
					x_q <= '0;
					y_q <= '0;
					z_q <= '0;
				end
				OP_MUL_DY: x_q <= sat_add(x_q, prod_rnd);
				OP_MUL_DZ: y_q <= sat_add(y_q, prod_rnd);
				OP_WB_DZ:  z_q <= sat_add(z_q, prod_rnd);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_ACCEPT: begin
				ra_q <= rand_a;
				rb_q <= rand_b;
				c_q  <= $signed(32'h4000_0000 - {1'b0, rand_b, 15'd0});
			end
			OP_MUL_TY: tx_q  <= prod_rnd;
			OP_MUL_DX: ty_q  <= prod_rnd;
			OP_SQ_Y:   acc_q <= prod_q[SQ_W-1:0];
			OP_SQ_Z:   acc_q <= acc_q + prod_q[SQ_W-1:0];
			OP_SQ_ACC: acc_q <= acc_q + prod_q[SQ_W-1:0];
			OP_OUT: begin
				pos_x           <= x_q;
				pos_y           <= y_q;
				pos_z           <= z_q;
				square_distance <= acc_q;
				distance        <= root;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign stat.sqrt_busy = sqrt_busy;
	assign stat.out_valid = out_valid_q;

endmodule

FILE: hdl/rws_ctrl.sv
`timescale 1ns / 1ps

module rws_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      req_type,
	input  logic            out_ready,
	input  rws_pkg::stat_t  stat,
	output rws_pkg::cmd_t   cmd
);
	import rws_pkg::*;

	state_t state_q, state_d;
	logic   out_free;

	assign out_free = !stat.out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (req_t'(req_type))
						REQ_LATTICE: state_d = ST_LAT;
						REQ_ISO:     state_d = ST_CC;
						REQ_ORIGIN:  state_d = ST_CLR;
						default:     state_d = ST_SQX;
					endcase
				end
			end
			ST_LAT:      state_d = ST_SQX;
			ST_CLR:      state_d = ST_SQX;
			ST_CC:       state_d = ST_ISO_LOAD;
			ST_ISO_LOAD: state_d = ST_ISO_RUN;
			ST_ISO_RUN:  if (!stat.sqrt_busy) state_d = ST_TX;
			ST_TX:       state_d = ST_TY;
			ST_TY:       state_d = ST_DX;
			ST_DX:       state_d = ST_DY;
			ST_DY:       state_d = ST_DZ;
			ST_DZ:       state_d = ST_WDZ;
			ST_WDZ:      state_d = ST_SQX;
			ST_SQX:      state_d = ST_SQY;
			ST_SQY:      state_d = ST_SQZ;
			ST_SQZ:      state_d = ST_ACC;
			ST_ACC:      state_d = ST_DLOAD;
			ST_DLOAD:    state_d = ST_DRUN;
			ST_DRUN:     if (!stat.sqrt_busy) state_d = ST_OUT;
			ST_OUT:      if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					cmd.op = OP_ACCEPT;
			end
			ST_LAT:      cmd.op = OP_LAT;
			ST_CLR:      cmd.op = OP_CLR;
			ST_CC:       cmd.op = OP_MUL_CC;
			ST_ISO_LOAD: cmd.op = OP_ISO_LOAD;
			ST_TX:       cmd.op = OP_MUL_TX;
			ST_TY:       cmd.op = OP_MUL_TY;
			ST_DX:       cmd.op = OP_MUL_DX;
			ST_DY:       cmd.op = OP_MUL_DY;
			ST_DZ:       cmd.op = OP_MUL_DZ;
			ST_WDZ:      cmd.op = OP_WB_DZ;
			ST_SQX:      cmd.op = OP_SQ_X;
			ST_SQY:      cmd.op = OP_SQ_Y;
			ST_SQZ:      cmd.op = OP_SQ_Z;
			ST_ACC:      cmd.op = OP_SQ_ACC;
			ST_DLOAD:    cmd.op = OP_DIST_LOAD;
			ST_OUT:      if (out_free) cmd.op = OP_OUT;
			default:     cmd.op = OP_NONE;
		endcase
	end

endmodule

FILE: hdl/random_walk_3d_step.sv
`timescale 1ns / 1ps

// 3D random walker, signed Q16.16 position, one result per request.
// Input channel in_valid/in_ready carries req_type (lattice step, isotropic
// step, back to origin) and two random fractions rand_a, rand_b.
// Output channel out_valid/out_ready returns the position, the squared
// distance (Q32.32) and the distance (Q16.16 floor square root).
// Config channel cfg_valid/cfg_ready writes step_length (Q8.16); always ready.
// The shared square root unit runs once for the distance of every request
// and once more for sin(theta) on an isotropic step, with the CORDIC
// running alongside it. One request is in flight at a time; in_ready is
// high only while the sequencer is idle, so a new request is taken in the
// cycle after the result is registered.
// The result sits in an output register, so the next request is taken while
// the receiver stalls; only a second finished result waits for it.
// Reset puts the walker at the origin and step_length back to 1.0.
module random_walk_3d_step #(
	parameter int CORDIC_STEPS = 18
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          req_type,
	input  logic [15:0]                         rand_a,
	input  logic [15:0]                         rand_b,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rws_pkg::LEN_W-1:0]           cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [rws_pkg::COORD_W-1:0]  pos_x,
	output logic signed [rws_pkg::COORD_W-1:0]  pos_y,
	output logic signed [rws_pkg::COORD_W-1:0]  pos_z,
	output logic [rws_pkg::SQ_W-1:0]            square_distance,
	output logic [rws_pkg::ROOT_W-1:0]          distance
);
	import rws_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	rws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rws_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.rand_a          (rand_a),
		.rand_b          (rand_b),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.square_distance (square_distance),
		.distance        (distance)
	);

endmodule
